[hw/rtl/bprh_pkg.sv]
// Shared types, register indexes and reset values for the button press/hold/repeat unit.
`default_nettype none
package bprh_pkg;

	localparam int unsigned TIME_W    = 32;
	localparam int unsigned DELAY_W   = 16;
	localparam int unsigned BUTTON_W  = 8;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = 16;

	typedef enum logic [1:0] {
		PH_RELEASED = 2'd0,
		PH_WAITING  = 2'd1,
		PH_PRESSED  = 2'd2,
		PH_HOLD     = 2'd3
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRESS_DELAY  = 3'd0,
		CFG_HOLD_DELAY   = 3'd1,
		CFG_REPEAT_FLOOR = 3'd2,
		CFG_REPEAT_DECAY = 3'd3,
		CFG_BUTTON_NUM   = 3'd4
	} cfg_idx_t;

	localparam logic [DELAY_W-1:0]  RST_PRESS_DELAY  = 16'd50;
	localparam logic [DELAY_W-1:0]  RST_HOLD_DELAY   = 16'd1000;
	localparam logic [DELAY_W-1:0]  RST_REPEAT_FLOOR = 16'd100;
	localparam logic [DELAY_W-1:0]  RST_REPEAT_DECAY = 16'd100;
	localparam logic [BUTTON_W-1:0] RST_BUTTON_NUM   = 8'd0;

	typedef struct packed {
		logic [DELAY_W-1:0] press_delay;
		logic [DELAY_W-1:0] hold_delay;
		logic [DELAY_W-1:0] repeat_floor;
		logic [DELAY_W-1:0] repeat_decay;
	} timing_cfg_t;

	typedef struct packed {
		phase_t             phase;
		logic               prev_level;
		logic [TIME_W-1:0]  phase_start;
		logic [DELAY_W-1:0] repeat_interval;
	} qual_state_t;

endpackage
`default_nettype wire

[hw/rtl/bprh_if.sv]
// Channel interfaces: sample input, event output and register write.
`default_nettype none
interface bprh_sample_if;
	logic                          valid;
	logic                          ready;
	logic                          level;
	logic [bprh_pkg::TIME_W-1:0]   now_ms;
	modport source (output valid, output level, output now_ms, input ready);
	modport sink   (input valid, input level, input now_ms, output ready);
endinterface

interface bprh_event_if;
	logic                          valid;
	logic                          ready;
	logic                          is_hold;
	logic [bprh_pkg::BUTTON_W-1:0] source_button;
	modport source (output valid, output is_hold, output source_button, input ready);
	modport sink   (input valid, input is_hold, input source_button, output ready);
endinterface

interface bprh_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [bprh_pkg::CFG_IDX_W-1:0] addr;
	logic [bprh_pkg::CFG_DAT_W-1:0] data;
	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/button_press_hold_repeat_unit.sv]
// Top level of the button press/hold qualifier with accelerating auto-repeat.
// Takes one sample word per clock while no event waits at the output. A sample
// is captured in an input register; when the output register is free or its
// event is being taken, the qualifier state is updated from it and any press
// or hold event lands in the output register, where it is offered. While an
// event waits, the state holds and an empty input register takes one more
// sample, then input stalls. Sustained rate is one sample per cycle otherwise.
// Register writes take effect at once and are always accepted.
`default_nettype none
module button_press_hold_repeat_unit (
	input  wire logic     clk,
	input  wire logic     arst_n,
	bprh_sample_if.sink   sample,
	bprh_event_if.source  evt,
	bprh_cfg_if.sink      cfg
);
	import bprh_pkg::*;

	timing_cfg_t         tcfg_q;
	logic [BUTTON_W-1:0] button_num_q;
	qual_state_t         state_q;
	qual_state_t         state_nxt;

	logic                v_s1;
	logic                level_s1;
	logic [TIME_W-1:0]   now_s1;

	logic                out_v_q;
	logic                out_hold_q;
	logic [BUTTON_W-1:0] out_button_q;

	logic                advance;
	logic                fire;
	logic                is_hold;

	assign advance      = !out_v_q || evt.ready;
	assign sample.ready = !v_s1 || advance;
	assign cfg.ready    = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tcfg_q.press_delay  <= RST_PRESS_DELAY;
			tcfg_q.hold_delay   <= RST_HOLD_DELAY;
			tcfg_q.repeat_floor <= RST_REPEAT_FLOOR;
			tcfg_q.repeat_decay <= RST_REPEAT_DECAY;
			button_num_q        <= RST_BUTTON_NUM;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				CFG_PRESS_DELAY:  tcfg_q.press_delay  <= cfg.data;
				CFG_HOLD_DELAY:   tcfg_q.hold_delay   <= cfg.data;
				CFG_REPEAT_FLOOR: tcfg_q.repeat_floor <= cfg.data;
				CFG_REPEAT_DECAY: tcfg_q.repeat_decay <= cfg.data;
				CFG_BUTTON_NUM:   button_num_q        <= cfg.data[BUTTON_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (sample.ready) begin
			v_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			level_s1 <= sample.level;
			now_s1   <= sample.now_ms;
		end
	end

	bprh_step u_step (
		.cur     (state_q),
		.tcfg    (tcfg_q),
		.level   (level_s1),
		.now_ms  (now_s1),
		.nxt     (state_nxt),
		.fire    (fire),
		.is_hold (is_hold)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase           <= PH_RELEASED;
			state_q.prev_level      <= 1'b0;
			state_q.phase_start     <= '0;
			state_q.repeat_interval <= '0;
		end else if (v_s1 && advance) begin
			state_q <= state_nxt;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (advance) begin
			out_v_q <= v_s1 && fire;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s1 && fire) begin
			out_hold_q   <= is_hold;
			out_button_q <= button_num_q;
		end
	end

	assign evt.valid         = out_v_q;
	assign evt.is_hold       = out_hold_q;
	assign evt.source_button = out_button_q;

endmodule
`default_nettype wire

[hw/rtl/bprh_step.sv]
// Next-state and event logic for one sample of the press/hold qualifier.
`default_nettype none
module bprh_step (
	input  bprh_pkg::qual_state_t          cur,
	input  bprh_pkg::timing_cfg_t          tcfg,
	input  logic                           level,
	input  logic [bprh_pkg::TIME_W-1:0]    now_ms,
	output bprh_pkg::qual_state_t          nxt,
	output logic                           fire,
	output logic                           is_hold
);
	import bprh_pkg::*;

	logic [DELAY_W-1:0] wait_len;
	logic [TIME_W-1:0]  due;
	logic               expired;
	logic [DELAY_W-1:0] shrunk;

	always_comb begin
		unique case (cur.phase)
			PH_WAITING: wait_len = tcfg.press_delay;
			PH_PRESSED: wait_len = tcfg.hold_delay;
			default:    wait_len = cur.repeat_interval;
		endcase
	end

	// modular sum, as the timestamp wraps
	assign due     = cur.phase_start + {{(TIME_W-DELAY_W){1'b0}}, wait_len};
	assign expired = due < now_ms;

	always_comb begin
		if (cur.repeat_interval > tcfg.repeat_floor) begin
			shrunk = (cur.repeat_interval > tcfg.repeat_decay) ?
				cur.repeat_interval - tcfg.repeat_decay : '0;
		end else begin
			shrunk = cur.repeat_interval;
		end
	end

	always_comb begin
		nxt            = cur;
		nxt.prev_level = level;
		fire           = 1'b0;
		is_hold        = 1'b0;
		unique case (cur.phase)
			PH_RELEASED: begin
				if (level && !cur.prev_level) begin
					nxt.phase       = PH_WAITING;
					nxt.phase_start = now_ms;
				end
			end
			PH_WAITING: begin
				if (!level) begin
					nxt.phase = PH_RELEASED;
				end else if (expired) begin
					nxt.phase       = PH_PRESSED;
					nxt.phase_start = now_ms;
					fire            = 1'b1;
				end
			end
			PH_PRESSED: begin
				if (!level) begin
					nxt.phase = PH_RELEASED;
				end else if (expired) begin
					nxt.phase           = PH_HOLD;
					nxt.phase_start     = now_ms;
					nxt.repeat_interval = tcfg.hold_delay;
					fire                = 1'b1;
					is_hold             = 1'b1;
				end
			end
			PH_HOLD: begin
				if (!level) begin
					nxt.phase = PH_RELEASED;
				end else if (expired) begin
					nxt.repeat_interval = shrunk;
					nxt.phase_start     = now_ms;
					fire                = 1'b1;
					is_hold             = 1'b1;
				end
			end
			default: begin
				nxt.phase = PH_RELEASED;
			end
		endcase
	end

endmodule
`default_nettype wire
